@@ rtl/b64e_pkg.sv @@
package b64e_pkg;

    // one base64 symbol: either a 6-bit sextet or an '=' pad
    typedef struct packed {
        logic       pad;
        logic [5:0] sext;
    } t_sym;

    // all characters caused by one input byte
    typedef struct packed {
        logic [1:0] last_idx;   // index of the final symbol, 0..3
        logic       last;       // word closes the message
        t_sym [3:0] syms;
    } t_group;

    localparam logic [7:0] PAD_CHAR  = 8'h3D;
    localparam logic [7:0] CHAR_UP_A = 8'h41;
    localparam logic [7:0] CHAR_LO_A = 8'h61;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_PLUS = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_ONE   = 2'd1;
    localparam logic [1:0] PH_TWO   = 2'd2;

    // sextet or pad to ASCII
    function automatic logic [7:0] sym_to_ascii(input t_sym s);
        logic [7:0] v;
        logic [7:0] c;
        v = {2'b00, s.sext};
        case (s.sext) inside
            [6'd0:6'd25]:  c = CHAR_UP_A + v;
            [6'd26:6'd51]: c = CHAR_LO_A + (v - 8'd26);
            [6'd52:6'd61]: c = CHAR_ZERO + (v - 8'd52);
            6'd62:         c = CHAR_PLUS;
            default:       c = CHAR_SLASH;
        endcase
        return s.pad ? PAD_CHAR : c;
    endfunction

endpackage

@@ rtl/b64e_front.sv @@
module b64e_front import b64e_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_message,
    output t_group     o_group
);

    logic [1:0] r_phase, n_phase;
    logic [3:0] r_left, n_left;
    t_group     grp;

    // split the byte into sextets, flush and pad at message end
    always_comb begin
        t_sym none;
        none        = '{pad: 1'b1, sext: 6'd0};
        grp.syms    = {none, none, none, none};
        grp.last    = i_end_of_message;
        grp.last_idx = 2'd0;
        n_phase     = r_phase;
        n_left      = r_left;
        case (r_phase)
            PH_ONE: begin
                grp.syms[0] = '{pad: 1'b0, sext: {r_left[1:0], i_data_byte[7:4]}};
                n_left      = i_data_byte[3:0];
                n_phase     = PH_TWO;
                if (i_end_of_message) begin
                    grp.syms[1]  = '{pad: 1'b0, sext: {i_data_byte[3:0], 2'b00}};
                    grp.last_idx = 2'd2;
                end
            end
            PH_TWO: begin
                grp.syms[0] = '{pad: 1'b0, sext: {r_left, i_data_byte[7:6]}};
                grp.syms[1] = '{pad: 1'b0, sext: i_data_byte[5:0]};
                grp.last_idx = 2'd1;
                n_left      = 4'd0;
                n_phase     = PH_START;
            end
            default: begin
                grp.syms[0] = '{pad: 1'b0, sext: i_data_byte[7:2]};
                n_left      = {2'b00, i_data_byte[1:0]};
                n_phase     = PH_ONE;
                if (i_end_of_message) begin
                    grp.syms[1]  = '{pad: 1'b0, sext: {i_data_byte[1:0], 4'b0000}};
                    grp.last_idx = 2'd3;
                end
            end
        endcase
        if (i_end_of_message) begin
            n_left  = 4'd0;
            n_phase = PH_START;
        end
    end

    assign o_group = grp;

    // group state advances per accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_left  <= 4'd0;
        end else if (i_push) begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

endmodule

@@ rtl/b64e_queue.sv @@
module b64e_queue import b64e_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_group i_group,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_not_empty,
    output t_group o_head
);

    t_group     r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    assign o_full      = r_count[1];
    assign o_not_empty = (r_count != 2'd0);
    assign o_head      = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/b64e_back.sv @@
module b64e_back import b64e_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_head_valid,
    input  t_group     i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_out_last
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_char;
    logic       r_last;
    logic       load;
    logic       at_end;

    // output register refills when empty or being taken
    assign load   = i_head_valid && (!r_valid || i_ready);
    assign at_end = (r_idx == i_head.last_idx);
    assign o_pop  = load && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx   <= at_end ? 2'd0 : r_idx + 2'd1;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= sym_to_ascii(i_head.syms[r_idx]);
            r_last <= i_head.last && at_end;
        end
    end

    assign o_valid    = r_valid;
    assign o_out_char = r_char;
    assign o_out_last = r_last;

endmodule

@@ rtl/base64_stream_encoder.sv @@
// Base64 stream encoder: one byte in, one to four characters out.
// The first character of a byte passes through the queue and then the output register.
// The output stage gives one character per cycle while i_ready is high; a byte makes
// one or two characters (up to four on a message end).
// A two-word queue sits between the byte splitter and the output stage.
// Synchronous active-low reset clears group state, queue and output valid.
module base64_stream_encoder import b64e_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_message,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_out_last
);

    t_group grp;
    t_group head;
    logic   push;
    logic   pop;
    logic   full;
    logic   not_empty;

    assign o_ready = !full;
    assign push    = i_valid && !full;

    b64e_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .o_group          (grp)
    );

    b64e_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_group     (grp),
        .i_pop       (pop),
        .o_full      (full),
        .o_not_empty (not_empty),
        .o_head      (head)
    );

    b64e_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (not_empty),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_char   (o_out_char),
        .o_out_last   (o_out_last)
    );

endmodule
